>>> design/pte_pkg.sv
// shared types, codes and constants of the palette texel expander
package pte_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int PALETTE_DEPTH = 256;

  localparam logic [1:0] REQ_PAL_LOAD   = 2'd0;
  localparam logic [1:0] REQ_GAMMA_LOAD = 2'd1;
  localparam logic [1:0] REQ_CONVERT    = 2'd2;

  localparam logic [2:0] TEX_NONE  = 3'd0;
  localparam logic [2:0] TEX_ALPHA = 3'd1;
  localparam logic [2:0] TEX_LUM   = 3'd2;
  localparam logic [2:0] TEX_GRAD  = 3'd3;
  localparam logic [2:0] TEX_RGBA  = 3'd4;

  localparam logic [1:0] CFG_TEXTURE_TYPE  = 2'd0;
  localparam logic [1:0] CFG_DITHER_ENABLE = 2'd1;

  localparam logic [7:0] ALPHA_OPAQUE      = 8'hFF;
  localparam logic [7:0] TRANSPARENT_INDEX = 8'hFF;
  localparam logic [7:0] GRADIENT_INDEX    = 8'hFF;
  localparam int         DITHER_SHIFT      = 6;

  typedef enum logic [1:0] {
    OP_PAL_LOAD,
    OP_GAMMA_LOAD,
    OP_CONVERT
  } op_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] entry_index;
    logic [7:0] load_red;
    logic [7:0] load_green;
    logic [7:0] load_blue;
    logic [7:0] gamma_level;
    logic [7:0] texel_index;
    logic       last_texel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic [2:0] final_type;
    logic       end_of_texture;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  addr;
    logic [23:0] data;
    logic        use_color;
    logic        dither;
    logic [7:0]  red_raw;
    logic [7:0]  alpha;
    logic [2:0]  final_type;
    logic        last;
  } qent_t;

  function automatic logic [7:0] dither_of(input logic [7:0] c);
    dither_of = c | (c >> DITHER_SHIFT);
  endfunction

endpackage

>>> design/pte_stream_if.sv
// valid/ready channel carrying one item per handshake
interface pte_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/palette_texel_expander_top.sv
// top level of the palette texel expander
//
// request channel takes one item per cycle while the queue has room: palette
// loads, gamma loads, texel conversions; other codes are taken and dropped.
// result channel gives one rgba item per conversion, in request order; loads
// give none. on the last texel of a texture the result also carries the
// final texture type.
// configuration writes (texture type, dither enable) go through cfg_we,
// cfg_index and cfg_data; the user must make them only while the block
// is idle; the block itself does not enforce this. a result passes
// through the queue, palette read, gamma read and result register.
// unstalled throughput: one item per cycle; palette and gamma rams each
// take one write and one read per cycle, the read in its own pipeline stage.
// when the receiver stalls the back pipeline holds; the queue keeps taking
// requests until it is full, then request.ready drops.
// reset clears the queue, the pipeline, the transparency flag and the
// registers; palette and gamma contents are undefined until loaded.
module palette_texel_expander_top #(
  parameter int QUEUE_DEPTH = pte_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  pte_stream_if.sink  request,
  pte_stream_if.source result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);
  import pte_pkg::*;

  logic [2:0] texture_type;
  logic       dither_enable;
  logic       push_valid;
  logic       push_ready;
  qent_t      push_data;
  logic       head_valid;
  logic       head_ready;
  qent_t      head;

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_type <= TEX_NONE;
      dither_enable <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TEXTURE_TYPE) begin
        texture_type <= cfg_data;
      end
      if (cfg_index == CFG_DITHER_ENABLE) begin
        dither_enable <= cfg_data[0];
      end
    end
  end

  pte_front u_front (
    .clk           (clk),
    .rst           (rst),
    .request       (request),
    .texture_type  (texture_type),
    .dither_enable (dither_enable),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  pte_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (head_valid),
    .out_ready (head_ready),
    .out_data  (head)
  );

  pte_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_ready (head_ready),
    .head       (head),
    .result     (result)
  );
endmodule

>>> design/pte_ram.sv
// generic single-write, single-read ram with registered read data
module pte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> design/pte_front.sv
// front end: accepts items, decodes them and tracks transparency per texture
module pte_front (
  input  logic           clk,
  input  logic           rst,
  pte_stream_if.sink     request,
  input  logic [2:0]     texture_type,
  input  logic           dither_enable,
  output logic           push_valid,
  input  logic           push_ready,
  output pte_pkg::qent_t push_data
);
  import pte_pkg::*;

  logic     transparent_seen;
  logic     transparent_seen_next;
  logic     known_req;
  logic     conv_accept;
  logic     hit_transparent;
  in_item_t it;
  qent_t    ent;

  assign it = request.data;
  assign known_req = (it.req_type == REQ_PAL_LOAD) || (it.req_type == REQ_GAMMA_LOAD) ||
                     (it.req_type == REQ_CONVERT);
  assign request.ready = push_ready;
  assign push_valid = request.valid && known_req;
  assign push_data = ent;
  assign conv_accept = request.valid && request.ready && (it.req_type == REQ_CONVERT);
  assign hit_transparent = (texture_type == TEX_ALPHA) && (it.texel_index == TRANSPARENT_INDEX);

  always_comb begin
    ent = '0;
    ent.op = OP_CONVERT;
    ent.addr = it.texel_index;
    ent.last = it.last_texel;
    unique case (it.req_type)
      REQ_PAL_LOAD: begin
        ent.op = OP_PAL_LOAD;
        ent.addr = it.entry_index;
        ent.data = {it.load_red, it.load_green, it.load_blue};
      end
      REQ_GAMMA_LOAD: begin
        ent.op = OP_GAMMA_LOAD;
        ent.addr = it.entry_index;
        ent.data = {16'd0, it.gamma_level};
      end
      default: begin
        unique case (texture_type)
          TEX_NONE: begin
            ent.use_color = 1'b1;
            ent.dither = dither_enable;
            ent.alpha = ALPHA_OPAQUE;
          end
          TEX_ALPHA: begin
            ent.use_color = !hit_transparent;
            ent.alpha = hit_transparent ? 8'd0 : ALPHA_OPAQUE;
          end
          TEX_LUM: begin
            ent.red_raw = it.texel_index;
          end
          TEX_GRAD: begin
            ent.addr = GRADIENT_INDEX;
            ent.use_color = 1'b1;
            ent.alpha = it.texel_index;
          end
          TEX_RGBA: begin
            ent.use_color = 1'b1;
            ent.alpha = it.texel_index;
          end
          default: begin
          end
        endcase
        if (it.last_texel) begin
          ent.final_type = texture_type;
          if ((texture_type == TEX_ALPHA) && !transparent_seen && !hit_transparent) begin
            ent.final_type = TEX_NONE;
          end
        end
      end
    endcase
  end

  always_comb begin
    transparent_seen_next = transparent_seen;
    if (conv_accept) begin
      priority if (it.last_texel) begin
        transparent_seen_next = 1'b0;
      end else if (hit_transparent) begin
        transparent_seen_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transparent_seen <= 1'b0;
    end else begin
      transparent_seen <= transparent_seen_next;
    end
  end
endmodule

>>> design/pte_fifo.sv
// short queue of decoded items between front and back
module pte_fifo #(
  parameter int DEPTH = pte_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pte_pkg::qent_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pte_pkg::qent_t out_data
);
  import pte_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qent_t         store [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data = store[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 1'b1)
    else $error("queue count did not shrink on pop");
`endif
endmodule

>>> design/pte_back.sv
// back end: table writes, palette and gamma lookups, result register
module pte_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  output logic           head_ready,
  input  pte_pkg::qent_t head,
  pte_stream_if.source   result
);
  import pte_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic        adv;
  logic        s1_valid;
  qent_t       s1;
  logic        s2_valid;
  qent_t       s2;
  logic        out_valid;
  out_item_t   out_reg;
  out_item_t   out_next;
  logic [23:0] pal_rdata;
  logic [7:0]  gam_r;
  logic [7:0]  gam_g;
  logic [7:0]  gam_b;
  logic        gam_we;
  logic        pal_we;

  assign adv = !out_valid || result.ready;
  assign head_ready = adv;
  assign pal_we = adv && head_valid && (head.op == OP_PAL_LOAD);
  assign gam_we = adv && s1_valid && (s1.op == OP_GAMMA_LOAD);

  pte_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (head.addr[AW-1:0]),
    .wdata (head.data),
    .re    (adv),
    .raddr (head.addr[AW-1:0]),
    .rdata (pal_rdata)
  );

  pte_ram #(.WIDTH(8), .DEPTH(PALETTE_DEPTH)) u_gamma_r (
    .clk   (clk),
    .we    (gam_we),
    .waddr (s1.addr[AW-1:0]),
    .wdata (s1.data[7:0]),
    .re    (adv),
    .raddr (pal_rdata[23:16]),
    .rdata (gam_r)
  );

  pte_ram #(.WIDTH(8), .DEPTH(PALETTE_DEPTH)) u_gamma_g (
    .clk   (clk),
    .we    (gam_we),
    .waddr (s1.addr[AW-1:0]),
    .wdata (s1.data[7:0]),
    .re    (adv),
    .raddr (pal_rdata[15:8]),
    .rdata (gam_g)
  );

  pte_ram #(.WIDTH(8), .DEPTH(PALETTE_DEPTH)) u_gamma_b (
    .clk   (clk),
    .we    (gam_we),
    .waddr (s1.addr[AW-1:0]),
    .wdata (s1.data[7:0]),
    .re    (adv),
    .raddr (pal_rdata[7:0]),
    .rdata (gam_b)
  );

  always_comb begin
    out_next.out_alpha = s2.alpha;
    out_next.final_type = s2.final_type;
    out_next.end_of_texture = s2.last;
    priority if (!s2.use_color) begin
      out_next.out_red = s2.red_raw;
      out_next.out_green = 8'd0;
      out_next.out_blue = 8'd0;
    end else if (s2.dither) begin
      out_next.out_red = dither_of(gam_r);
      out_next.out_green = dither_of(gam_g);
      out_next.out_blue = dither_of(gam_b);
    end else begin
      out_next.out_red = gam_r;
      out_next.out_green = gam_g;
      out_next.out_blue = gam_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= head_valid;
      s2_valid <= s1_valid && (s1.op == OP_CONVERT);
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= head;
      s2 <= s1;
      out_reg <= out_next;
    end
  end

  assign result.valid = out_valid;
  assign result.data = out_reg;

`ifndef NO_ASSERTIONS
  a_s2_convert: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> s2.op == OP_CONVERT)
    else $error("non-convert item reached lookup stage");

  a_out_from_s2: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s2_valid))
    else $error("result appeared without a looked-up item");

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !adv) |=> s2_valid && $stable(s2))
    else $error("lookup stage changed while stalled");
`endif
endmodule

>>> bench/tb_palette_texel_expander_top.sv
// self-checking testbench for the palette texel expander: random loads and texel conversions
module tb_palette_texel_expander_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pte_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [1:0] CFG_UNUSED_B = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 150;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [2:0] cfg_data;

  pte_stream_if #(.payload_t(in_item_t)) req_if ();
  pte_stream_if #(.payload_t(out_item_t)) res_if ();

  palette_texel_expander_top DUT (
    .clk(clk),
    .rst(rst),
    .request(req_if),
    .result(res_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mirror of the block state
  logic [23:0] pal_mem [256];
  logic [7:0] gamma_mem [256];
  logic transparent_seen;
  logic [2:0] tex_type_reg;
  logic dither_reg;

  in_item_t request_backlog [$];
  out_item_t rgba_expect [$];
  int send_idle_pct;
  int recv_stall_pct;
  int errors;

  function automatic logic [23:0] corrected_color(input logic [7:0] idx);
    logic [23:0] raw;
    raw = pal_mem[idx];
    return {gamma_mem[raw[23:16]], gamma_mem[raw[15:8]], gamma_mem[raw[7:0]]};
  endfunction

  function automatic bit expand_request(input in_item_t it, output out_item_t res);
    logic [23:0] rgb;
    logic [7:0] alpha;
    logic [2:0] ftype;
    res = '0;
    rgb = '0;
    alpha = '0;
    ftype = TEX_NONE;
    if (it.req_type == REQ_PAL_LOAD) begin
      pal_mem[it.entry_index] = {it.load_red, it.load_green, it.load_blue};
      return 1'b0;
    end
    if (it.req_type == REQ_GAMMA_LOAD) begin
      gamma_mem[it.entry_index] = it.gamma_level;
      return 1'b0;
    end
    if (it.req_type != REQ_CONVERT) begin
      return 1'b0;
    end
    case (tex_type_reg)
      TEX_NONE: begin
        rgb = corrected_color(it.texel_index);
        if (dither_reg) begin
          rgb = rgb | ((rgb >> 6) & 24'h030303);
        end
        alpha = ALPHA_OPAQUE;
      end
      TEX_ALPHA: begin
        if (it.texel_index == TRANSPARENT_INDEX) begin
          transparent_seen = 1'b1;
        end else begin
          rgb = corrected_color(it.texel_index);
          alpha = ALPHA_OPAQUE;
        end
      end
      TEX_LUM: begin
        rgb = {it.texel_index, 16'h0000};
      end
      TEX_GRAD: begin
        rgb = corrected_color(GRADIENT_INDEX);
        alpha = it.texel_index;
      end
      TEX_RGBA: begin
        rgb = corrected_color(it.texel_index);
        alpha = it.texel_index;
      end
      default: begin
      end
    endcase
    if (it.last_texel) begin
      ftype = tex_type_reg;
      if (ftype == TEX_ALPHA && !transparent_seen) begin
        ftype = TEX_NONE;
      end
      transparent_seen = 1'b0;
    end
    res.out_red = rgb[23:16];
    res.out_green = rgb[15:8];
    res.out_blue = rgb[7:0];
    res.out_alpha = alpha;
    res.final_type = ftype;
    res.end_of_texture = it.last_texel;
    return 1'b1;
  endfunction

  function automatic in_item_t pal_item(input logic [7:0] idx, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b);
    in_item_t it;
    it = '0;
    it.req_type = REQ_PAL_LOAD;
    it.entry_index = idx;
    it.load_red = r;
    it.load_green = g;
    it.load_blue = b;
    return it;
  endfunction

  function automatic in_item_t gamma_item(input logic [7:0] idx, input logic [7:0] lvl);
    in_item_t it;
    it = '0;
    it.req_type = REQ_GAMMA_LOAD;
    it.entry_index = idx;
    it.gamma_level = lvl;
    return it;
  endfunction

  function automatic in_item_t texel_item(input logic [7:0] t, input logic last);
    in_item_t it;
    it = '0;
    it.req_type = REQ_CONVERT;
    it.texel_index = t;
    it.last_texel = last;
    return it;
  endfunction

  function automatic in_item_t random_request();
    in_item_t it;
    int pick;
    it.entry_index = 8'($urandom);
    it.load_red = 8'($urandom);
    it.load_green = 8'($urandom);
    it.load_blue = 8'($urandom);
    it.gamma_level = 8'($urandom);
    it.texel_index = ($urandom_range(9) == 0) ? TRANSPARENT_INDEX : 8'($urandom);
    it.last_texel = ($urandom_range(7) == 0);
    pick = $urandom_range(99);
    if (pick < 70) begin
      it.req_type = REQ_CONVERT;
    end else if (pick < 82) begin
      it.req_type = REQ_PAL_LOAD;
    end else if (pick < 94) begin
      it.req_type = REQ_GAMMA_LOAD;
    end else begin
      it.req_type = REQ_UNKNOWN;
    end
    return it;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    out_item_t res;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        if (expand_request(req_if.data, res)) begin
          rgba_expect.push_back(res);
        end
      end
      if (!req_if.valid || req_if.ready) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.data <= request_backlog.pop_front();
          req_if.valid <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_results
    out_item_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (res_if.valid && res_if.ready) begin
        if (rgba_expect.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %p", $time, res_if.data);
        end else begin
          want = rgba_expect.pop_front();
          check_field("out_red", want.out_red, res_if.data.out_red);
          check_field("out_green", want.out_green, res_if.data.out_green);
          check_field("out_blue", want.out_blue, res_if.data.out_blue);
          check_field("out_alpha", want.out_alpha, res_if.data.out_alpha);
          check_field("final_type", 8'(want.final_type), 8'(res_if.data.final_type));
          check_field("end_of_texture", 8'(want.end_of_texture),
                      8'(res_if.data.end_of_texture));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || cfg_we || rst) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_palette_texel_expander_top NOT OK");
    $finish;
  end

  task automatic wait_idle();
    while (request_backlog.size() != 0 || req_if.valid || rgba_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TEXTURE_TYPE) begin
      tex_type_reg = val;
    end else if (idx == CFG_DITHER_ENABLE) begin
      dither_reg = val[0];
    end
  endtask

  task automatic set_mode(input logic [2:0] ttype, input logic dith);
    write_reg(CFG_TEXTURE_TYPE, ttype);
    write_reg(CFG_DITHER_ENABLE, {2'($urandom), dith});
  endtask

  initial begin : stimulus
    int n;
    in_item_t it;
    logic [2:0] phase_type [RANDOM_PHASES];
    logic phase_dither [RANDOM_PHASES];
    int send_pcts [4];
    int recv_pcts [4];
    phase_type = '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd1};
    phase_dither = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    send_pcts = '{0, 57, 0, 28};
    recv_pcts = '{0, 0, 57, 28};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    res_if.ready = 1'b0;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    transparent_seen = 1'b0;
    tex_type_reg = TEX_NONE;
    dither_reg = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // fill both tables so every lookup hits a written entry
    for (int i = 0; i < 256; i++) begin
      request_backlog.push_back(pal_item(8'(i), 8'($urandom), 8'($urandom), 8'($urandom)));
      request_backlog.push_back(gamma_item(8'(i), 8'($urandom)));
    end
    wait_idle();

    // directed part
    request_backlog.push_back(pal_item(8'h00, 8'h00, 8'h00, 8'h00));
    request_backlog.push_back(pal_item(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    request_backlog.push_back(gamma_item(8'h00, 8'hFF));
    request_backlog.push_back(gamma_item(8'hFF, 8'hC1));
    request_backlog.push_back(texel_item(8'h00, 1'b0));
    request_backlog.push_back(texel_item(8'hFF, 1'b1));
    wait_idle();
    set_mode(TEX_NONE, 1'b1);
    request_backlog.push_back(texel_item(8'h00, 1'b0));
    request_backlog.push_back(texel_item(8'hFF, 1'b1));
    wait_idle();
    set_mode(TEX_ALPHA, 1'b1);
    request_backlog.push_back(texel_item(8'h05, 1'b0));
    request_backlog.push_back(texel_item(TRANSPARENT_INDEX, 1'b0));
    request_backlog.push_back(texel_item(8'h07, 1'b1));
    request_backlog.push_back(texel_item(8'h03, 1'b1));
    wait_idle();
    set_mode(TEX_LUM, 1'b1);
    request_backlog.push_back(texel_item(8'h00, 1'b0));
    request_backlog.push_back(texel_item(8'hFF, 1'b1));
    wait_idle();
    set_mode(TEX_GRAD, 1'b0);
    request_backlog.push_back(texel_item(8'h00, 1'b0));
    request_backlog.push_back(texel_item(8'hC8, 1'b1));
    wait_idle();
    set_mode(TEX_RGBA, 1'b1);
    request_backlog.push_back(texel_item(8'hFF, 1'b0));
    request_backlog.push_back(texel_item(8'h00, 1'b1));
    wait_idle();
    for (int ty = 5; ty < 8; ty++) begin
      set_mode(3'(ty), 1'b1);
      request_backlog.push_back(texel_item(8'h0A, 1'b1));
      wait_idle();
    end
    it = texel_item(8'h11, 1'b1);
    it.req_type = REQ_UNKNOWN;
    request_backlog.push_back(it);
    wait_idle();
    write_reg(CFG_UNUSED_A, 3'b111);
    write_reg(CFG_UNUSED_B, 3'b010);
    request_backlog.push_back(texel_item(8'h22, 1'b1));
    wait_idle();

    // random part
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p % 3 == 0) begin
        write_reg(($urandom_range(1) == 0) ? CFG_UNUSED_A : CFG_UNUSED_B, 3'($urandom));
      end
      set_mode(phase_type[p], phase_dither[p]);
      send_idle_pct = send_pcts[p % 4];
      recv_stall_pct = recv_pcts[p % 4];
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        it = random_request();
        request_backlog.push_back(it);
        if (it.req_type != REQ_UNKNOWN) begin
          n++;
        end
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb_palette_texel_expander_top OK");
    end else begin
      $display("tb_palette_texel_expander_top NOT OK");
    end
    $finish;
  end

endmodule
